// ----- src/afd_pkg.sv -----
`timescale 1ns / 1ps
package afd_pkg;
   localparam int FieldBits = 32;

   localparam logic [1:0] PH_SPACE = 2'd0;
   localparam logic [1:0] PH_SIGN  = 2'd1;
   localparam logic [1:0] PH_DIGIT = 2'd2;
   localparam logic [1:0] PH_DONE  = 2'd3;

   localparam logic [7:0] MinLenReset = 8'd27;

   // classified byte passed from front to back
   typedef struct packed {
      logic       summary;
      logic [7:0] data;
   } afd_item_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  content_byte;
      logic        frame_ok;
      logic [31:0] frame_count;
      logic [31:0] command_id;
      logic [31:0] content_length;
      logic        content_kept;
   } afd_rsp_type;
endpackage

// ----- src/afd_if.sv -----
`timescale 1ns / 1ps
interface afd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

// ----- src/afd_rsp_if.sv -----
`timescale 1ns / 1ps
interface afd_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  content_byte;
   logic        frame_ok;
   logic [31:0] frame_count;
   logic [31:0] command_id;
   logic [31:0] content_length;
   logic        content_kept;
   modport source (output valid, kind, content_byte, frame_ok, frame_count, command_id,
                   content_length, content_kept, input ready);
   modport sink (input valid, kind, content_byte, frame_ok, frame_count, command_id,
                 content_length, content_kept, output ready);
endinterface

// ----- src/afd_front.sv -----
`timescale 1ns / 1ps
// head/tail hunt: passes head markers, in-frame bytes and tail markers to the back end
module afd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [7:0]            in_byte,
   output logic                  in_ready,
   output logic                  out_valid,
   output afd_pkg::afd_item_type out_item,
   input  logic                  out_ready
);
   import afd_pkg::*;
   logic       in_frame_ff, in_frame_in;
   logic [2:0] head_ff, head_in, tail_ff, tail_in, hn, tn;
   logic       ov_ff, ov_in;
   afd_item_type oi_ff, oi_in;
   logic       take;

   always_comb begin
      hn = 3'd0;
      if (in_byte == "/") hn = (head_ff == 3'd2) ? 3'd3 : 3'd1;
      else if (in_byte == "f") hn = (head_ff == 3'd1 || head_ff == 3'd3) ? 3'd2 : 3'd0;
      else if (in_byte == "b") hn = (head_ff == 3'd3) ? 3'd4 : 3'd0;
      tn = 3'd0;
      if (in_byte == "/") tn = (tail_ff == 3'd2) ? 3'd3 : 3'd1;
      else if (in_byte == "b") tn = (tail_ff == 3'd1 || tail_ff == 3'd3) ? 3'd2 : 3'd0;
      else if (in_byte == "f") tn = (tail_ff == 3'd3) ? 3'd4 : 3'd0;
   end

   assign in_ready = !ov_ff || out_ready;
   assign take = in_valid && in_ready;

   always_comb begin
      in_frame_in = in_frame_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      ov_in = ov_ff && !out_ready;
      oi_in = oi_ff;
      if (take) begin
         if (!in_frame_ff) begin
            head_in = hn;
            // head start item resets the back end
            if (hn == 3'd4) begin
               in_frame_in = 1'b1;
               head_in = 3'd0;
               tail_in = 3'd2;
               ov_in = 1'b1;
               oi_in = '{summary: 1'b1, data: 8'd0};
            end
         end else begin
            tail_in = tn;
            ov_in = 1'b1;
            oi_in = '{summary: 1'b0, data: in_byte};
            if (tn == 3'd4) begin
               in_frame_in = 1'b0;
               tail_in = 3'd0;
               head_in = 3'd0;
               oi_in = '{summary: 1'b1, data: 8'd1};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         head_ff <= 3'd0;
         tail_ff <= 3'd0;
         ov_ff <= 1'b0;
      end else begin
         in_frame_ff <= in_frame_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         ov_ff <= ov_in;
      end
      oi_ff <= oi_in;
   end

   assign out_valid = ov_ff;
   assign out_item = oi_ff;
endmodule

// ----- src/afd_queue.sv -----
`timescale 1ns / 1ps
// two-entry queue between front and back
module afd_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  afd_pkg::afd_item_type in_item,
   output logic                  in_ready,
   output logic                  out_valid,
   output afd_pkg::afd_item_type out_item,
   input  logic                  out_ready
);
   import afd_pkg::*;
   afd_item_type mem_ff [2];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic push, pop;
   assign in_ready = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_item = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) mem_ff[wp_ff] <= in_item;
   end
endmodule

// ----- src/afd_back.sv -----
`timescale 1ns / 1ps
// field split, number parse, content delay and summary
module afd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [7:0]            min_len,
   input  logic                  in_valid,
   input  afd_pkg::afd_item_type in_item,
   output logic                  in_ready,
   output logic                  out_valid,
   output afd_pkg::afd_rsp_type  out_rsp,
   input  logic                  out_ready
);
   import afd_pkg::*;
   logic [2:0]  fidx_ff, fidx_in;
   logic [1:0]  dm_ff, dm_in, ph_ff, ph_in;
   logic        neg_ff, neg_in, err_ff, err_in;
   logic [32:0] acc_ff, acc_in;
   logic [31:0] cnt_ff, cnt_in, cmd_ff, cmd_in, len_ff, len_in, cc_ff, cc_in;
   logic [7:0]  fb_ff, fb_in, d0_ff, d0_in, d1_ff, d1_in;
   logic [7:0]  fb_nx;
   logic [1:0]  held_ff, held_in;
   logic        ov_ff, ov_in;
   afd_rsp_type or_ff, or_in;
   logic        take, dig, sp, ok, kept;
   logic [7:0]  c;
   logic [3:0]  dv;
   logic [32:0] lim, nacc;
   logic [31:0] fin;

   assign in_ready = !ov_ff || out_ready;
   assign take = in_valid && in_ready;
   assign c = in_item.data;
   assign dig = c >= "0" && c <= "9";
   assign sp = c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
   assign dv = 4'(c - "0");
   assign lim = {1'b0, 32'h7fffffff} + {32'd0, neg_ff};
   assign nacc = 33'(acc_ff * 33'd10) + {29'd0, dv};
   assign fin = neg_ff ? 32'd0 - acc_ff[31:0] : acc_ff[31:0];
   // frame length including the byte being taken, saturating
   assign fb_nx = (fb_ff != 8'd255) ? fb_ff + 8'd1 : fb_ff;
   assign ok = !err_ff && fidx_ff >= 3'd5 && fb_nx >= min_len;
   assign kept = !($signed(len_ff) > 0 && cc_ff != len_ff);

   always_comb begin
      fidx_in = fidx_ff; dm_in = dm_ff; ph_in = ph_ff; neg_in = neg_ff;
      err_in = err_ff; acc_in = acc_ff; cnt_in = cnt_ff; cmd_in = cmd_ff;
      len_in = len_ff; cc_in = cc_ff; fb_in = fb_ff; d0_in = d0_ff;
      d1_in = d1_ff; held_in = held_ff;
      ov_in = ov_ff && !out_ready;
      or_in = or_ff;
      if (take && in_item.summary && c == 8'd0) begin
         // frame start
         fidx_in = 3'd0; dm_in = 2'd0; ph_in = PH_SPACE; neg_in = 1'b0;
         acc_in = '0; cnt_in = '0; cmd_in = '0; len_in = '0; cc_in = '0;
         held_in = 2'd0; err_in = 1'b0; fb_in = 8'd4;
      end else if (take) begin
         fb_in = fb_nx;
         if (in_item.summary) begin
            ov_in = 1'b1;
            or_in = '0;
            or_in.kind = 1'b1;
            held_in = 2'd0;
            if (ok) begin
               or_in.frame_ok = 1'b1;
               or_in.frame_count = cnt_ff;
               or_in.command_id = cmd_ff;
               or_in.content_length = kept ? len_ff : 32'd0;
               or_in.content_kept = kept;
            end
         end else if (fidx_ff < 3'd5) begin
            dm_in = (c == "I") ? dm_ff + 2'd1 : 2'd0;
            if (c == "I" && dm_ff == 2'd2) begin
               dm_in = 2'd0;
               if (fidx_ff >= 3'd1 && fidx_ff <= 3'd3 && ph_ff < PH_DIGIT) err_in = 1'b1;
               if (fidx_ff == 3'd1) cnt_in = fin;
               if (fidx_ff == 3'd2) cmd_in = fin;
               if (fidx_ff == 3'd3) len_in = fin;
               ph_in = PH_SPACE; neg_in = 1'b0; acc_in = '0;
               held_in = 2'd0;
               fidx_in = fidx_ff + 3'd1;
            end else if (fidx_ff >= 3'd1 && fidx_ff <= 3'd3) begin
               if (ph_ff == PH_SPACE && sp) begin
               end else if (ph_ff == PH_SPACE && (c == "+" || c == "-")) begin
                  neg_in = c == "-";
                  ph_in = PH_SIGN;
               end else if (ph_ff == PH_SPACE || ph_ff == PH_SIGN) begin
                  if (dig) begin
                     acc_in = {29'd0, dv};
                     ph_in = PH_DIGIT;
                  end else begin
                     err_in = 1'b1;
                     ph_in = PH_DONE;
                  end
               end else if (ph_ff == PH_DIGIT) begin
                  if (!dig) ph_in = PH_DONE;
                  else begin
                     acc_in = nacc;
                     if (nacc > lim || acc_ff > 33'd214748364) begin
                        err_in = 1'b1;
                        ph_in = PH_DONE;
                     end
                  end
               end
            end else if (fidx_ff == 3'd4) begin
               if (held_ff == 2'd2) begin
                  ov_in = 1'b1;
                  or_in = '0;
                  or_in.content_byte = d0_ff;
                  if (cc_ff != 32'hffffffff) cc_in = cc_ff + 32'd1;
                  d0_in = d1_ff;
                  d1_in = c;
               end else begin
                  if (held_ff[0]) d1_in = c;
                  else d0_in = c;
                  held_in = held_ff + 2'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fidx_ff <= 3'd0; dm_ff <= 2'd0; ph_ff <= PH_SPACE; neg_ff <= 1'b0;
         err_ff <= 1'b0; acc_ff <= '0; held_ff <= 2'd0; ov_ff <= 1'b0;
         fb_ff <= 8'd0; cc_ff <= '0; cnt_ff <= '0; cmd_ff <= '0; len_ff <= '0;
      end else begin
         fidx_ff <= fidx_in; dm_ff <= dm_in; ph_ff <= ph_in; neg_ff <= neg_in;
         err_ff <= err_in; acc_ff <= acc_in; held_ff <= held_in; ov_ff <= ov_in;
         fb_ff <= fb_in; cc_ff <= cc_in; cnt_ff <= cnt_in; cmd_ff <= cmd_in;
         len_ff <= len_in;
      end
      d0_ff <= d0_in;
      d1_ff <= d1_in;
      or_ff <= or_in;
   end

   assign out_valid = ov_ff;
   assign out_rsp = or_ff;
endmodule

// ----- src/ascii_frame_deframer.sv -----
`timescale 1ns / 1ps
// ascii frame deframer: one request byte per cycle, sustained while responses are not stalled
// a response passes through the front register, the queue and the back register;
// content bytes are held two bytes late
// throughput: one request per cycle while the response side does not stall
// reset: synchronous, active high; hunting for a head, min frame length 27
module ascii_frame_deframer (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata,
   afd_req_if.sink    req,
   afd_rsp_if.source  rsp
);
   import afd_pkg::*;
   logic [7:0]   min_len_ff;
   logic         f_valid, f_ready, q_valid, q_ready, b_valid;
   afd_item_type f_item, q_item;
   afd_rsp_type  b_rsp;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) min_len_ff <= MinLenReset;
      else if (csr_we) min_len_ff <= csr_wdata;
   end

   // front: head/tail hunt
   afd_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_byte(req.in_byte), .in_ready(req.ready),
      .out_valid(f_valid), .out_item(f_item), .out_ready(f_ready)
   );

   // queue lets either side stall alone
   afd_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_item(f_item), .in_ready(f_ready),
      .out_valid(q_valid), .out_item(q_item), .out_ready(q_ready)
   );

   // back: fields, numbers, content and summary
   afd_back u_back (
      .clock(clock), .reset(reset), .min_len(min_len_ff),
      .in_valid(q_valid), .in_item(q_item), .in_ready(q_ready),
      .out_valid(b_valid), .out_rsp(b_rsp), .out_ready(rsp.ready)
   );

   assign rsp.valid = b_valid;
   assign rsp.kind = b_rsp.kind;
   assign rsp.content_byte = b_rsp.content_byte;
   assign rsp.frame_ok = b_rsp.frame_ok;
   assign rsp.frame_count = b_rsp.frame_count;
   assign rsp.command_id = b_rsp.command_id;
   assign rsp.content_length = b_rsp.content_length;
   assign rsp.content_kept = b_rsp.content_kept;
endmodule

// ----- src/afd_checker.sv -----
`timescale 1ns / 1ps
module afd_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_kind,
   input logic rsp_frame_ok,
   input logic rsp_content_kept,
   input logic [7:0] rsp_content_byte
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("response dropped");
   a_content: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_kind |-> !rsp_frame_ok && !rsp_content_kept)
      else $error("content carries summary bits");
   a_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind |-> rsp_content_byte == 8'd0)
      else $error("summary carries byte");
   a_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_content_kept |-> rsp_frame_ok) else $error("kept without ok");
endmodule

bind ascii_frame_deframer afd_checker u_chk (
   .clock(clock), .reset(reset), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_kind(rsp.kind), .rsp_frame_ok(rsp.frame_ok),
   .rsp_content_kept(rsp.content_kept), .rsp_content_byte(rsp.content_byte)
);

// ----- verif/tb_ascii_frame_deframer.sv -----
`timescale 1ns / 1ps
module tb_ascii_frame_deframer;
   import afd_pkg::*;

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic [7:0] csr_wdata;

   afd_req_if req ();
   afd_rsp_if rsp ();

   ascii_frame_deframer DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req       (req.sink),
      .rsp       (rsp.source)
   );

   // ---------------------------------------------------------------- clock
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // ---------------------------------------------------------------- predictor state
   logic [7:0]  min_len;
   logic        framing;
   logic [2:0]  head_st;
   logic [2:0]  tail_st;
   logic [2:0]  field_no;
   logic [1:0]  delim_run;
   logic [1:0]  num_phase;
   logic        num_neg;
   logic [63:0] num_mag;
   logic [31:0] got_count;
   logic [31:0] got_command;
   logic [31:0] got_length;
   logic [31:0] content_seen;
   logic [7:0]  frame_len;
   logic [7:0]  held [2];
   int          held_n;
   logic        bad_frame;

   afd_rsp_type expected_q [$];
   logic [7:0]  frame_bytes [$];

   int errors;
   int bytes_sent;
   int frames_built;
   int results_seen;
   int summaries_seen;
   int send_idle;
   int recv_idle;
   int hold_req;
   int hold_seen;
   int hold_left;
   longint cycles;

   function automatic bit is_ws(logic [7:0] c);
      return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic [2:0] head_adv(logic [2:0] s, logic [7:0] c);
      if (c == "/") return (s == 3'd2) ? 3'd3 : 3'd1;
      if (c == "f") return (s == 3'd1 || s == 3'd3) ? 3'd2 : 3'd0;
      if (c == "b") return (s == 3'd3) ? 3'd4 : 3'd0;
      return 3'd0;
   endfunction

   function automatic logic [2:0] tail_adv(logic [2:0] s, logic [7:0] c);
      if (c == "/") return (s == 3'd2) ? 3'd3 : 3'd1;
      if (c == "b") return (s == 3'd1 || s == 3'd3) ? 3'd2 : 3'd0;
      if (c == "f") return (s == 3'd3) ? 3'd4 : 3'd0;
      return 3'd0;
   endfunction

   // append one byte to the frame under construction
   function automatic void put_byte(logic [7:0] b);
      frame_bytes = {frame_bytes, b};
   endfunction

   function automatic void num_reset();
      num_phase = PH_SPACE;
      num_neg   = 1'b0;
      num_mag   = 64'd0;
   endfunction

   // stoi-like digit accumulation, one byte at a time
   function automatic void num_take(logic [7:0] c);
      bit          digit;
      logic [63:0] lim;
      digit = (c >= "0" && c <= "9");
      lim   = (64'd1 << (FieldBits - 1)) - (num_neg ? 64'd0 : 64'd1);
      if (num_phase == PH_SPACE) begin
         if (is_ws(c)) return;
         if (c == "+" || c == "-") begin
            num_neg   = (c == "-");
            num_phase = PH_SIGN;
            return;
         end
      end
      if (num_phase == PH_SPACE || num_phase == PH_SIGN) begin
         if (digit) begin
            num_mag   = 64'(c - "0");
            num_phase = PH_DIGIT;
         end else begin
            bad_frame = 1'b1;
            num_phase = PH_DONE;
         end
         return;
      end
      if (num_phase == PH_DIGIT) begin
         if (!digit) begin
            num_phase = PH_DONE;
            return;
         end
         num_mag = num_mag * 10 + 64'(c - "0");
         if (num_mag > lim) begin
            bad_frame = 1'b1;
            num_phase = PH_DONE;
         end
      end
   endfunction

   function automatic logic [31:0] num_value();
      logic [31:0] m;
      m = num_mag[31:0];
      if (num_phase == PH_SPACE || num_phase == PH_SIGN) bad_frame = 1'b1;
      return num_neg ? (32'd0 - m) : m;
   endfunction

   function automatic void deframer_reset();
      min_len      = MinLenReset;
      framing      = 1'b0;
      head_st      = 3'd0;
      tail_st      = 3'd0;
      field_no     = 3'd0;
      delim_run    = 2'd0;
      num_reset();
      got_count    = '0;
      got_command  = '0;
      got_length   = '0;
      content_seen = '0;
      frame_len    = '0;
      held[0]      = '0;
      held[1]      = '0;
      held_n       = 0;
      bad_frame    = 1'b0;
   endfunction

   // advance the predictor by one accepted byte; returns 1 when a response is due
   function automatic bit deframe_byte(input logic [7:0] c, output afd_rsp_type r);
      bit ok;
      bit kept;
      r = '0;
      if (!framing) begin
         head_st = head_adv(head_st, c);
         if (head_st == 3'd4) begin
            framing      = 1'b1;
            head_st      = 3'd0;
            tail_st      = 3'd2;
            field_no     = 3'd0;
            delim_run    = 2'd0;
            num_reset();
            got_count    = '0;
            got_command  = '0;
            got_length   = '0;
            content_seen = '0;
            held_n       = 0;
            bad_frame    = 1'b0;
            frame_len    = 8'd4;
         end
         return 1'b0;
      end
      if (frame_len != 8'hFF) frame_len++;
      tail_st = tail_adv(tail_st, c);
      if (tail_st == 3'd4) begin
         ok      = !bad_frame && field_no >= 3'd5 && frame_len >= min_len;
         framing = 1'b0;
         tail_st = 3'd0;
         head_st = 3'd0;
         held_n  = 0;
         r.kind  = 1'b1;
         if (ok) begin
            kept = !($signed(got_length) > 0 && content_seen != got_length);
            r.frame_ok       = 1'b1;
            r.frame_count    = got_count;
            r.command_id     = got_command;
            r.content_length = kept ? got_length : 32'd0;
            r.content_kept   = kept;
         end
         return 1'b1;
      end
      if (field_no >= 3'd5) return 1'b0;
      delim_run = (c == "I") ? delim_run + 2'd1 : 2'd0;
      if (delim_run == 2'd3) begin
         delim_run = 2'd0;
         case (field_no)
            3'd1: got_count   = num_value();
            3'd2: got_command = num_value();
            3'd3: got_length  = num_value();
            default: ;
         endcase
         num_reset();
         held_n = 0;
         field_no++;
         return 1'b0;
      end
      if (field_no >= 3'd1 && field_no <= 3'd3) begin
         num_take(c);
         return 1'b0;
      end
      if (field_no == 3'd4) begin
         if (held_n >= 2) begin
            r.content_byte = held[0];
            if (content_seen != 32'hFFFF_FFFF) content_seen++;
            held[0] = held[1];
            held[1] = c;
            return 1'b1;
         end
         held[held_n] = c;
         held_n++;
      end
      return 1'b0;
   endfunction

   // ---------------------------------------------------------------- receiver side
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
         hold_left <= 0;
         hold_seen <= 0;
      end else if (hold_left > 0) begin
         rsp.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_req != hold_seen) begin
         // long stall so the block backs up into the request side
         hold_seen <= hold_req;
         hold_left <= 400;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // response checker
   always @(posedge clock) begin
      afd_rsp_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         results_seen++;
         if (expected_q.size() == 0) begin
            $error("unexpected response kind=%0d byte=%0h", rsp.kind, rsp.content_byte);
            errors++;
         end else begin
            want = expected_q.pop_front();
            if (want.kind) summaries_seen++;
            if (rsp.kind !== want.kind) begin
               $error("kind: expected %0h actual %0h", want.kind, rsp.kind);
               errors++;
            end
            if (rsp.content_byte !== want.content_byte) begin
               $error("content_byte: expected %0h actual %0h",
                      want.content_byte, rsp.content_byte);
               errors++;
            end
            if (rsp.frame_ok !== want.frame_ok) begin
               $error("frame_ok: expected %0h actual %0h", want.frame_ok, rsp.frame_ok);
               errors++;
            end
            if (rsp.frame_count !== want.frame_count) begin
               $error("frame_count: expected %0h actual %0h",
                      want.frame_count, rsp.frame_count);
               errors++;
            end
            if (rsp.command_id !== want.command_id) begin
               $error("command_id: expected %0h actual %0h",
                      want.command_id, rsp.command_id);
               errors++;
            end
            if (rsp.content_length !== want.content_length) begin
               $error("content_length: expected %0h actual %0h",
                      want.content_length, rsp.content_length);
               errors++;
            end
            if (rsp.content_kept !== want.content_kept) begin
               $error("content_kept: expected %0h actual %0h",
                      want.content_kept, rsp.content_kept);
               errors++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 2000000) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------- request side
   task automatic send_byte(input logic [7:0] b);
      afd_rsp_type r;
      while ($urandom_range(99) < send_idle) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid   <= 1'b1;
      req.in_byte <= b;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      bytes_sent++;
      if (deframe_byte(b, r)) expected_q = {expected_q, r};
   endtask

   task automatic send_frame_bytes();
      while (frame_bytes.size() > 0) send_byte(frame_bytes.pop_front());
      frames_built++;
   endtask

   task automatic add_str(input string s);
      for (int i = 0; i < s.len(); i++) put_byte(s[i]);
   endtask

   // stop offering and wait for every expected response, plus latency slack
   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (expected_q.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_min_len(input logic [7:0] v);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      min_len = v;
   endtask

   // random number text: valid, extreme, overflowing or malformed
   function automatic string rand_number(input int lenhint);
      case ($urandom_range(15))
         0: return "2147483647";
         1: return "-2147483648";
         2: return "2147483648";
         3: return "-2147483649";
         4: return "99999999999";
         5: return "";
         6: return "-";
         7: return " \t+x";
         8: return $sformatf(" %0dzz", $urandom_range(500));
         9: return $sformatf("\n-%0d", $urandom());
         10: return $sformatf("%0d", $signed($urandom()));
         default: return (lenhint >= 0) ? $sformatf("%0d", lenhint)
                                        : $sformatf("+%0d", $urandom_range(9999));
      endcase
   endfunction

   task automatic build_random_frame();
      int clen;
      int ndelim;
      int lenfield;
      clen = ($urandom_range(19) == 0) ? $urandom_range(300) : $urandom_range(12);
      lenfield = ($urandom_range(2) == 0) ? -1 :
                 (($urandom_range(1) == 0) ? clen : $urandom_range(15));
      ndelim = ($urandom_range(9) == 0) ? $urandom_range(4) : 5;
      if ($urandom_range(3) == 0) add_str("xx/");
      add_str("/f/b");
      for (int i = $urandom_range(4); i > 0; i--)
         put_byte(8'($urandom_range(65, 72)));
      for (int d = 1; d <= ndelim; d++) begin
         add_str("III");
         if (d <= 3) add_str(rand_number((d == 3) ? lenfield : -1));
         else if (d == 4) begin
            for (int i = 0; i < clen; i++)
               put_byte(($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                 : 8'($urandom_range(48, 90)));
         end else if ($urandom_range(1)) add_str("trail");
      end
      if ($urandom_range(14) != 0) add_str("/b/f");
   endtask

   // ---------------------------------------------------------------- tests
   task automatic test_directed();
      add_str("/f/bhdrIII1III2III5IIIhelloIII/b/f"); send_frame_bytes();
      add_str("/f/b/f"); send_frame_bytes();
      add_str("/f/bIII 2147483647III-2147483648III0IIIabIII/b/f"); send_frame_bytes();
      add_str("/f/bIII2147483648III1III1IIIxIII/b/f"); send_frame_bytes();
      add_str("/f/bIII\t+12abcIII-IIIIII IIIcontentIII/b/f"); send_frame_bytes();
      add_str("/f/bIII7III8III3IIIabcdefIII/b/f"); send_frame_bytes();
      add_str("/f/bIII7III8III-3IIIabIIIjunk/b/f"); send_frame_bytes();
      add_str("/f/bIII1III2III3IIIabc/b/f"); send_frame_bytes();
      add_str("/f/bIIIIIIIIIIIIIII/b/f"); send_frame_bytes();
      put_byte(8'h00); put_byte(8'hFF);
      add_str("//f/f/b");
      put_byte(8'h80); put_byte(8'h7F);
      add_str("III1III2III2III");
      put_byte(8'hFF); put_byte(8'h00);
      add_str("IIIII/b/b/f"); send_frame_bytes();
      write_min_len(8'd0);
      add_str("/f/b/f/f/bIII/b/f"); send_frame_bytes();
      write_min_len(8'd255);
      add_str("/f/bIII1III2III0III");
      for (int i = 0; i < 260; i++) put_byte(8'($urandom_range(48, 57)));
      add_str("III/b/f"); send_frame_bytes();
      add_str("/f/bIII1III2III3IIIabcIII/b/f"); send_frame_bytes();
      write_min_len(MinLenReset);
   endtask

   task automatic test_random_phase(input int s_idle, input int r_idle, input int nbytes);
      int stop_at;
      send_idle = s_idle;
      recv_idle = r_idle;
      stop_at = bytes_sent + nbytes;
      while (bytes_sent < stop_at) begin
         if ($urandom_range(7) == 0) begin
            for (int i = $urandom_range(1, 10); i > 0; i--)
               put_byte(8'($urandom_range(255)));
         end
         build_random_frame();
         send_frame_bytes();
      end
      write_min_len(8'($urandom_range(255) >> $urandom_range(3)));
   endtask

   task automatic test_backpressure();
      hold_req++;
      add_str("/f/bIII1III2III150III");
      for (int i = 0; i < 150; i++) put_byte(8'($urandom_range(255)));
      add_str("III/b/f");
      send_frame_bytes();
      drain();
   endtask

   initial begin
      reset       = 1'b1;
      csr_we      = 1'b0;
      csr_wdata   = '0;
      req.valid   = 1'b0;
      req.in_byte = '0;
      errors = 0; bytes_sent = 0; frames_built = 0;
      results_seen = 0; summaries_seen = 0; cycles = 0;
      send_idle = 29; recv_idle = 80; hold_req = 0;
      deframer_reset();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_phase(29, 80, 200);
      test_backpressure();
      test_random_phase(80, 29, 200);
      test_random_phase(0, 0, 200);
      write_min_len(8'd6);
      test_random_phase(0, 0, 40);
      drain();

      $display("covered %0d request bytes in %0d frames, %0d responses (%0d summaries)",
               bytes_sent, frames_built, results_seen, summaries_seen);
      $display("min length settings 0, 6, 27, 255 and random; long receiver stall");
      if (errors == 0 && expected_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
